### src/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg: shared types and codes of the terminal line editor
// Opcodes, result kinds, character codes, datapath action and select codes,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam logic [1:0] OP_KEY   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [2:0] K_ECHO   = 3'd0;
   localparam logic [2:0] K_CHAR   = 3'd1;
   localparam logic [2:0] K_EOF    = 3'd2;
   localparam logic [2:0] K_TOP    = 3'd3;
   localparam logic [2:0] K_CLEAN  = 3'd4;
   localparam logic [2:0] K_CONT   = 3'd5;
   localparam logic [2:0] K_NONE   = 3'd6;
   localparam logic [2:0] K_REFUSE = 3'd7;

   localparam logic [7:0] CH_CTRL_C = 8'h03;
   localparam logic [7:0] CH_CTRL_G = 8'h07;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_CTRL_P = 8'h10;
   localparam logic [7:0] CH_CTRL_Z = 8'h1A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DEL    = 8'h7F;

   localparam logic [7:0] COL_MAX     = 8'hFF;
   localparam logic [3:0] ERASE_LIMIT = 4'd8;
   localparam logic [3:0] TAB_WIDTH   = 4'd8;

   // key classes
   localparam logic [2:0] KC_CR    = 3'd0;
   localparam logic [2:0] KC_BS    = 3'd1;
   localparam logic [2:0] KC_EOF   = 3'd2;
   localparam logic [2:0] KC_PRINT = 3'd3;
   localparam logic [2:0] KC_OTHER = 3'd4;

   // output data selects
   localparam logic [2:0] SEL_CHAR = 3'd0;
   localparam logic [2:0] SEL_ZERO = 3'd1;
   localparam logic [2:0] SEL_CR   = 3'd2;
   localparam logic [2:0] SEL_LF   = 3'd3;
   localparam logic [2:0] SEL_BS   = 3'd4;
   localparam logic [2:0] SEL_SP   = 3'd5;
   localparam logic [2:0] SEL_MEM  = 3'd6;

   // datapath actions
   localparam logic [3:0] ACT_NONE      = 4'd0;
   localparam logic [3:0] ACT_LATCH     = 4'd1;
   localparam logic [3:0] ACT_CR_COMMIT = 4'd2;
   localparam logic [3:0] ACT_FLUSH     = 4'd3;
   localparam logic [3:0] ACT_NL_CURSOR = 4'd4;
   localparam logic [3:0] ACT_STORE_KEY = 4'd5;
   localparam logic [3:0] ACT_ADV       = 4'd6;
   localparam logic [3:0] ACT_BS_START  = 4'd7;
   localparam logic [3:0] ACT_BS_ERASE  = 4'd8;
   localparam logic [3:0] ACT_RD_START  = 4'd9;
   localparam logic [3:0] ACT_REP_DEC   = 4'd10;

   typedef struct packed {
      logic [3:0] act;
      logic       emit;
      logic [2:0] kind;
      logic [2:0] sel;
      logic       last;
   } tle_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] key_class;
      logic       is_tab;
      logic [2:0] sig_kind;
      logic       line_ready;
      logic       bs_ok;
      logic       print_ok;
      logic       read_ok;
      logic       wr_newline;
      logic       erase_zero;
      logic       rep_one;
      logic       out_free;
   } tle_status_type;

endpackage

### src/tle_channels.sv
// ----------------------------------------------------------------------------
// tle_channels: request and response channels of the terminal line editor
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tle_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] char_code;

   modport source (output valid, output opcode, output char_code, input ready);
   modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface tle_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data;
   logic       last;

   modport source (output valid, output kind, output data, output last, input ready);
   modport sink (input valid, input kind, input data, input last, output ready);
endinterface

### src/tle_datapath.sv
// ----------------------------------------------------------------------------
// tle_datapath: line store, column store, counters and output register
// Executes one controller action per cycle and reports decoded status.
// ----------------------------------------------------------------------------
module tle_datapath #(
   parameter int LINE_DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_opcode,
   input  logic [7:0]              req_char_code,
   input  tle_pkg::tle_cmd_type    cmd,
   output tle_pkg::tle_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_kind,
   output logic [7:0]              rsp_data,
   output logic                    rsp_last
);
   import tle_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = $clog2(LINE_DEPTH + 1);

   logic [7:0] line_mem [LINE_DEPTH];
   logic [7:0] col_mem [LINE_DEPTH];

   logic [1:0]    op_ff;
   logic [7:0]    ch_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rdidx_ff, rdidx_in;
   logic [7:0]    cursor_ff, cursor_in;
   logic          ready_ff, ready_in;
   logic [3:0]    rep_ff, rep_in;
   logic [7:0]    line_rd_ff;
   logic [7:0]    col_rd_ff;
   logic          valid_ff, valid_in;
   logic [2:0]    kind_ff;
   logic [7:0]    data_ff;
   logic          last_ff;

   logic [2:0]    key_class;
   logic [2:0]    sig_kind;
   logic          is_tab;
   logic          out_free;
   logic [CW-1:0] count_dec;
   logic [CW-1:0] rdidx_inc;
   logic [3:0]    spaces;
   logic [8:0]    tab_sum;
   logic [7:0]    cursor_sat;
   logic [7:0]    cursor_tab;
   logic [7:0]    diff;
   logic [3:0]    erase_n;
   logic          line_we;
   logic [7:0]    line_wd;
   logic [7:0]    data_sel;

   always_comb begin
      if (ch_ff == CH_CR) begin
         key_class = KC_CR;
      end else if (ch_ff == CH_BS || ch_ff == CH_DEL) begin
         key_class = KC_BS;
      end else if (ch_ff == CH_CTRL_Z) begin
         key_class = KC_EOF;
      end else if (ch_ff == CH_TAB || (ch_ff >= CH_SPACE && ch_ff < CH_DEL)) begin
         key_class = KC_PRINT;
      end else begin
         key_class = KC_OTHER;
      end
      case (ch_ff)
         CH_CTRL_Z: sig_kind = K_EOF;
         CH_CTRL_C: sig_kind = K_TOP;
         CH_CTRL_G: sig_kind = K_CLEAN;
         CH_CTRL_P: sig_kind = K_CONT;
         default:   sig_kind = K_CHAR;
      endcase
   end

   assign is_tab    = (ch_ff == CH_TAB);
   assign out_free  = !valid_ff || rsp_ready;
   assign count_dec = count_ff - CW'(1);
   assign rdidx_inc = rdidx_ff + CW'(1);
   assign spaces    = TAB_WIDTH - {1'b0, cursor_ff[2:0]};
   assign tab_sum   = {1'b0, cursor_ff} + {5'b0, spaces};
   assign cursor_tab = tab_sum[8] ? COL_MAX : tab_sum[7:0];
   assign cursor_sat = (cursor_ff == COL_MAX) ? COL_MAX : cursor_ff + 8'd1;
   assign diff      = cursor_ff - col_rd_ff;
   assign erase_n   = (cursor_ff <= col_rd_ff) ? 4'd0 :
                      (diff > {4'b0, ERASE_LIMIT}) ? ERASE_LIMIT : diff[3:0];

   always_comb begin
      status.op         = op_ff;
      status.key_class  = key_class;
      status.is_tab     = is_tab;
      status.sig_kind   = sig_kind;
      status.line_ready = ready_ff;
      status.bs_ok      = (count_ff != '0);
      status.print_ok   = (count_ff < CW'(LINE_DEPTH - 1));
      status.read_ok    = ready_ff && (rdidx_ff < count_ff);
      status.wr_newline = (ch_ff == CH_LF);
      status.erase_zero = (erase_n == 4'd0);
      status.rep_one    = (rep_ff == 4'd1);
      status.out_free   = out_free;
   end

   always_comb begin
      count_in  = count_ff;
      rdidx_in  = rdidx_ff;
      cursor_in = cursor_ff;
      ready_in  = ready_ff;
      rep_in    = rep_ff;
      line_we   = 1'b0;
      line_wd   = ch_ff;
      case (cmd.act)
         ACT_CR_COMMIT: begin
            if (count_ff < CW'(LINE_DEPTH)) begin
               line_we  = 1'b1;
               line_wd  = CH_LF;
               count_in = count_ff + CW'(1);
            end
            cursor_in = '0;
            rdidx_in  = '0;
            ready_in  = 1'b1;
         end
         ACT_FLUSH: begin
            count_in  = '0;
            rdidx_in  = '0;
            cursor_in = '0;
         end
         ACT_NL_CURSOR: cursor_in = '0;
         ACT_STORE_KEY: begin
            line_we  = 1'b1;
            count_in = count_ff + CW'(1);
            if (is_tab) begin
               cursor_in = cursor_tab;
               rep_in    = spaces;
            end else begin
               cursor_in = cursor_sat;
            end
         end
         ACT_ADV:      cursor_in = cursor_sat;
         ACT_BS_START: count_in = count_dec;
         ACT_BS_ERASE: begin
            cursor_in = cursor_ff - {4'b0, erase_n};
            rep_in    = erase_n;
         end
         ACT_RD_START: begin
            if (rdidx_inc >= count_ff) begin
               ready_in = 1'b0;
               count_in = '0;
               rdidx_in = '0;
            end else begin
               rdidx_in = rdidx_inc;
            end
         end
         ACT_REP_DEC: rep_in = rep_ff - 4'd1;
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.sel)
         SEL_CHAR: data_sel = ch_ff;
         SEL_CR:   data_sel = CH_CR;
         SEL_LF:   data_sel = CH_LF;
         SEL_BS:   data_sel = CH_BS;
         SEL_SP:   data_sel = CH_SPACE;
         SEL_MEM:  data_sel = line_rd_ff;
         default:  data_sel = 8'h00;
      endcase
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[count_ff[AW-1:0]] <= line_wd;
      end
      if (cmd.act == ACT_STORE_KEY) begin
         col_mem[count_ff[AW-1:0]] <= cursor_ff;
      end
      if (cmd.act == ACT_RD_START) begin
         line_rd_ff <= line_mem[rdidx_ff[AW-1:0]];
      end
      if (cmd.act == ACT_BS_START) begin
         col_rd_ff <= col_mem[count_dec[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act == ACT_LATCH) begin
         op_ff <= req_opcode;
         ch_ff <= req_char_code;
      end
      if (cmd.emit) begin
         kind_ff <= cmd.kind;
         data_ff <= data_sel;
         last_ff <= cmd.last;
      end
      rep_ff <= rep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rdidx_ff  <= '0;
         cursor_ff <= '0;
         ready_ff  <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rdidx_ff  <= rdidx_in;
         cursor_ff <= cursor_in;
         ready_ff  <= ready_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_data  = data_ff;
   assign rsp_last  = last_ff;

endmodule

### src/tle_ctrl.sv
// ----------------------------------------------------------------------------
// tle_ctrl: sequencing state machine of the terminal line editor
// Decodes items, orders actions, emits one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module tle_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tle_pkg::tle_status_type status,
   output tle_pkg::tle_cmd_type    cmd
);
   import tle_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_ONE     = 4'd2;
   localparam logic [3:0] S_NL_CR   = 4'd3;
   localparam logic [3:0] S_NL_LF   = 4'd4;
   localparam logic [3:0] S_SIGNAL  = 4'd5;
   localparam logic [3:0] S_TAB     = 4'd6;
   localparam logic [3:0] S_BS_READ = 4'd7;
   localparam logic [3:0] S_BS1     = 4'd8;
   localparam logic [3:0] S_BS2     = 4'd9;
   localparam logic [3:0] S_BS3     = 4'd10;
   localparam logic [3:0] S_RD      = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   logic [2:0] sel_ff, sel_in;
   logic       follow;

   assign follow = (status.op == OP_KEY) &&
                   (status.key_class == KC_EOF || status.key_class == KC_OTHER);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      sel_in   = sel_ff;
      cmd.act  = ACT_NONE;
      cmd.emit = 1'b0;
      cmd.kind = K_ECHO;
      cmd.sel  = SEL_ZERO;
      cmd.last = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.act  = ACT_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (status.op)
               OP_KEY: begin
                  if (status.line_ready) begin
                     kind_in  = K_REFUSE;
                     sel_in   = SEL_CHAR;
                     state_in = S_ONE;
                  end else begin
                     case (status.key_class)
                        KC_CR: begin
                           cmd.act  = ACT_CR_COMMIT;
                           state_in = S_NL_CR;
                        end
                        KC_BS: begin
                           if (status.bs_ok) begin
                              cmd.act  = ACT_BS_START;
                              state_in = S_BS_READ;
                           end
                        end
                        KC_PRINT: begin
                           if (status.print_ok) begin
                              cmd.act = ACT_STORE_KEY;
                              if (status.is_tab) begin
                                 state_in = S_TAB;
                              end else begin
                                 kind_in  = K_ECHO;
                                 sel_in   = SEL_CHAR;
                                 state_in = S_ONE;
                              end
                           end
                        end
                        default: begin
                           cmd.act  = ACT_FLUSH;
                           state_in = S_NL_CR;
                        end
                     endcase
                  end
               end
               OP_READ: begin
                  if (status.read_ok) begin
                     cmd.act  = ACT_RD_START;
                     state_in = S_RD;
                  end else begin
                     kind_in  = K_NONE;
                     sel_in   = SEL_ZERO;
                     state_in = S_ONE;
                  end
               end
               OP_WRITE: begin
                  if (status.wr_newline) begin
                     cmd.act  = ACT_NL_CURSOR;
                     state_in = S_NL_CR;
                  end else begin
                     cmd.act  = ACT_ADV;
                     kind_in  = K_ECHO;
                     sel_in   = SEL_CHAR;
                     state_in = S_ONE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ONE: begin
            cmd.kind = kind_ff;
            cmd.sel  = sel_ff;
            cmd.last = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_NL_CR: begin
            cmd.sel = SEL_CR;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_NL_LF;
            end
         end
         S_NL_LF: begin
            cmd.sel  = SEL_LF;
            cmd.last = !follow;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = follow ? S_SIGNAL : S_IDLE;
            end
         end
         S_SIGNAL: begin
            cmd.kind = status.sig_kind;
            cmd.sel  = (status.sig_kind == K_CHAR) ? SEL_CHAR : SEL_ZERO;
            cmd.last = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TAB: begin
            cmd.sel  = SEL_SP;
            cmd.last = status.rep_one;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.act  = ACT_REP_DEC;
               if (status.rep_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_BS_READ: begin
            if (status.erase_zero) begin
               state_in = S_IDLE;
            end else begin
               cmd.act  = ACT_BS_ERASE;
               state_in = S_BS1;
            end
         end
         S_BS1: begin
            cmd.sel = SEL_BS;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_BS2;
            end
         end
         S_BS2: begin
            cmd.sel = SEL_SP;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_BS3;
            end
         end
         S_BS3: begin
            cmd.sel  = SEL_BS;
            cmd.last = status.rep_one;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.act  = ACT_REP_DEC;
               state_in = status.rep_one ? S_IDLE : S_BS1;
            end
         end
         S_RD: begin
            cmd.kind = K_CHAR;
            cmd.sel  = SEL_MEM;
            cmd.last = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      sel_ff  <= sel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor: line-editing front end for a character terminal
// Collects and echoes keystrokes, serves completed lines to a reader and
// prints written bytes while tracking the cursor column.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item: opcode (keystroke, read, write) and char_code.
//   rsp_ch returns the items it causes, one per cycle at most, in order;
//   last marks the final one. Some keystrokes cause no result at all.
//   An item is taken only when the controller is idle: it is accepted,
//   then decoded, then its results are emitted one at a time (backspace
//   first reads the column store). The worst case, backspace over a tab,
//   gives 24 results. The next item is taken only after the sequencer has
//   loaded the last result into the single output register.
//   When the receiver stalls, the output register holds its item and the
//   sequencer waits; nothing is dropped.
//   Reset empties the line, clears the column, read position and line-ready
//   flag; the line and column stores need no clearing.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
   parameter int LINE_DEPTH = 256
) (
   input logic      clock,
   input logic      reset,
   tle_req_if.sink  req_ch,
   tle_rsp_if.source rsp_ch
);
   import tle_pkg::*;

   tle_cmd_type    cmd;
   tle_status_type status;

   tle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tle_datapath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_opcode    (req_ch.opcode),
      .req_char_code (req_ch.char_code),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_kind      (rsp_ch.kind),
      .rsp_data      (rsp_ch.data),
      .rsp_last      (rsp_ch.last)
   );

endmodule
